// ===== rtl/ufsef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufsef_pkg
// Shared types and field widths for the spanning-edge filter.
// ----------------------------------------------------------------------------
package ufsef_pkg;

  localparam int NODE_W  = 10;
  localparam int LABEL_W = 20;
  localparam int COUNT_W = 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIX,
    ST_EMIT
  } ufsef_state_t;

endpackage

// ===== rtl/ufsef_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufsef_table
// Parent table: one synchronous memory, one write and one registered read
// port, with a clearing pass after reset that sets every entry to its index.
// ----------------------------------------------------------------------------
module ufsef_table #(
  parameter int NODES = 1024,
  parameter int IW    = $clog2(NODES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [IW-1:0] rd_addr,
  output logic [IW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [IW-1:0] wr_data,
  output logic          busy
);

  logic [IW-1:0] parent_mem [NODES];
  logic [IW-1:0] rd_data_r;
  logic [IW-1:0] clr_r;
  logic [IW-1:0] clr_nxt;
  logic          busy_r;
  logic          busy_nxt;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [IW-1:0] mem_wd;

  always_comb begin
    clr_nxt  = clr_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      if (clr_r == IW'(NODES - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        clr_nxt = clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      clr_r  <= clr_nxt;
    end
  end

  // clearing sweep owns the write port until it finishes
  assign mem_we = busy_r | wr_en;
  assign mem_wa = busy_r ? clr_r : wr_addr;
  assign mem_wd = busy_r ? clr_r : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      parent_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= parent_mem[rd_addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// ===== rtl/union_find_spanning_edge_filter.sv =====
`timescale 1ns / 1ps
// Per edge in range: each endpoint's chain is walked to its root, then
// walked again to point each node at that root, one chain step per read,
// set by the single read port of the parent table. An edge with an endpoint
// out of range goes straight to ST_EMIT. The result word is registered in
// ST_EMIT once the output slot is free. After reset a clearing pass resets
// every parent entry; no edge is taken until it ends. Count resets to zero.
// ----------------------------------------------------------------------------
// union_find_spanning_edge_filter
// Union-find with full path compression over a memory-held parent table;
// passes each edge out flagged as a spanning-tree edge or rejected.
// ----------------------------------------------------------------------------
module union_find_spanning_edge_filter #(
  parameter int NODES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ufsef_pkg::NODE_W-1:0]  in_node_a,
  input  logic [ufsef_pkg::NODE_W-1:0]  in_node_b,
  input  logic [ufsef_pkg::LABEL_W-1:0] in_edge_label,
  input  logic                          in_last_edge,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_joined,
  output logic [ufsef_pkg::NODE_W-1:0]  out_tree_from,
  output logic [ufsef_pkg::NODE_W-1:0]  out_tree_to,
  output logic [ufsef_pkg::LABEL_W-1:0] out_tree_label,
  output logic [ufsef_pkg::COUNT_W-1:0] out_accepted_total,
  output logic                          out_done_res
);

  import ufsef_pkg::*;

  localparam int IW = $clog2(NODES);

  ufsef_state_t         state_r, state_nxt;
  logic                 sel_b_r, sel_b_nxt;
  logic [IW-1:0]        cur_r, cur_nxt;
  logic [IW-1:0]        start_r, start_nxt;
  logic [IW-1:0]        root_r, root_nxt;
  logic [IW-1:0]        root_a_r, root_a_nxt;
  logic [NODE_W-1:0]    a_r, a_nxt;
  logic [NODE_W-1:0]    b_r, b_nxt;
  logic [LABEL_W-1:0]   label_r, label_nxt;
  logic                 last_r, last_nxt;
  logic                 joined_r, joined_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_joined_r, out_joined_nxt;
  logic [NODE_W-1:0]    out_from_r, out_from_nxt;
  logic [NODE_W-1:0]    out_to_r, out_to_nxt;
  logic [LABEL_W-1:0]   out_label_r, out_label_nxt;
  logic [COUNT_W-1:0]   out_total_r, out_total_nxt;
  logic                 out_done_r, out_done_nxt;

  logic [IW-1:0]        rd_addr;
  logic [IW-1:0]        rd_data;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [IW-1:0]        wr_data;
  logic                 tbl_busy;
  logic                 slot_free;
  logic                 in_range;

  ufsef_table #(
    .NODES (NODES),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .busy    (tbl_busy)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_range  = (32'(in_node_a) < NODES) && (32'(in_node_b) < NODES);
  assign in_stall  = tbl_busy || (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    sel_b_nxt      = sel_b_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    root_nxt       = root_r;
    root_a_nxt     = root_a_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    label_nxt      = label_r;
    last_nxt       = last_r;
    joined_nxt     = joined_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_joined_nxt = out_joined_r;
    out_from_nxt   = out_from_r;
    out_to_nxt     = out_to_r;
    out_label_nxt  = out_label_r;
    out_total_nxt  = out_total_r;
    out_done_nxt   = out_done_r;
    rd_addr        = cur_r;
    wr_en          = 1'b0;
    wr_addr        = cur_r;
    wr_data        = root_r;

    unique case (state_r)
      ST_IDLE: begin
        rd_addr = IW'(in_node_a);
        if (in_valid && !in_stall) begin
          a_nxt      = in_node_a;
          b_nxt      = in_node_b;
          label_nxt  = in_edge_label;
          last_nxt   = in_last_edge;
          sel_b_nxt  = 1'b0;
          cur_nxt    = IW'(in_node_a);
          start_nxt  = IW'(in_node_a);
          joined_nxt = 1'b0;
          state_nxt  = in_range ? ST_WALK : ST_EMIT;
        end
      end

      // climb towards the root, one parent read per cycle
      ST_WALK: begin
        if (rd_data == cur_r) begin
          root_nxt  = cur_r;
          cur_nxt   = start_r;
          rd_addr   = start_r;
          state_nxt = ST_FIX;
        end else begin
          cur_nxt = rd_data;
          rd_addr = rd_data;
        end
      end

      // walk the same chain again, pointing each node at the root
      ST_FIX: begin
        if (cur_r != root_r) begin
          wr_en   = 1'b1;
          wr_addr = cur_r;
          wr_data = root_r;
          cur_nxt = rd_data;
          rd_addr = rd_data;
        end else if (!sel_b_r) begin
          root_a_nxt = root_r;
          sel_b_nxt  = 1'b1;
          cur_nxt    = IW'(b_r);
          start_nxt  = IW'(b_r);
          rd_addr    = IW'(b_r);
          state_nxt  = ST_WALK;
        end else begin
          // both roots known: link the first under the second
          if (root_a_r != root_r) begin
            wr_en      = 1'b1;
            wr_addr    = root_a_r;
            wr_data    = root_r;
            joined_nxt = 1'b1;
            if (count_r != {COUNT_W{1'b1}}) begin
              count_nxt = count_r + 1'b1;
            end
          end
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_joined_nxt = joined_r;
          out_from_nxt   = a_r;
          out_to_nxt     = b_r;
          out_label_nxt  = label_r;
          out_total_nxt  = count_r;
          out_done_nxt   = last_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      sel_b_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      sel_b_r     <= sel_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    root_r       <= root_nxt;
    root_a_r     <= root_a_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    label_r      <= label_nxt;
    last_r       <= last_nxt;
    joined_r     <= joined_nxt;
    out_joined_r <= out_joined_nxt;
    out_from_r   <= out_from_nxt;
    out_to_r     <= out_to_nxt;
    out_label_r  <= out_label_nxt;
    out_total_r  <= out_total_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_joined         = out_joined_r;
  assign out_tree_from      = out_from_r;
  assign out_tree_to        = out_to_r;
  assign out_tree_label     = out_label_r;
  assign out_accepted_total = out_total_r;
  assign out_done_res       = out_done_r;

endmodule
